>>> src/line_pixel_rasterizer_top_defines.svh
// assertion macros for the line pixel rasterizer
`ifndef LINE_PIXEL_RASTERIZER_TOP_DEFINES_SVH
`define LINE_PIXEL_RASTERIZER_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
// checked only outside reset
`define LPR_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);
// checked at every edge, reset included
`define LPR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);
`else
`define LPR_ASSERT(lbl, prop, msg)
`define LPR_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> src/lpr_pkg.sv
`default_nettype none

package lpr_pkg;

  // coordinate format
  localparam int COORD_W = 13;
  localparam int FRAC_W  = 8;
  localparam int INT_W   = COORD_W - FRAC_W;
  localparam int MARK_W  = 8;

  // grid
  localparam int GRID  = 32;
  localparam int POS_W = $clog2(GRID);

  // slope arithmetic widths
  localparam int DX_W  = COORD_W;
  localparam int DY_W  = COORD_W + 1;
  localparam int DEN_W = DX_W + FRAC_W;
  localparam int NUM_W = 2 * COORD_W + 2;
  localparam int DVD_W = NUM_W - 1;
  localparam int Q_W   = DVD_W - FRAC_W + 3;
  localparam int CNT_W = $clog2(DVD_W);

  typedef struct packed {
    logic [COORD_W-1:0] start_x;
    logic [COORD_W-1:0] start_y;
    logic [COORD_W-1:0] end_x;
    logic [COORD_W-1:0] end_y;
    logic [MARK_W-1:0]  pen_mark;
  } in_t;

  typedef struct packed {
    logic [POS_W-1:0]  pixel_column;
    logic [POS_W-1:0]  pixel_row;
    logic [MARK_W-1:0] mark;
    logic              off_grid;
    logic              last;
  } out_t;

  typedef enum logic [1:0] {
    MODE_VERT,
    MODE_HORIZ,
    MODE_SLOPE
  } mode_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SUM,
    ST_QGO,
    ST_QWAIT,
    ST_SGO,
    ST_SWAIT,
    ST_EMIT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic mul;
    logic sum;
    logic div_start;
    logic div_sel_step;
    logic cap_num;
    logic cap_step;
    logic emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic slope;
    logic last;
    logic div_done;
    logic out_free;
  } sts_t;

endpackage

`default_nettype wire

>>> src/lpr_div.sv
`default_nettype none
`include "line_pixel_rasterizer_top_defines.svh"

module lpr_div import lpr_pkg::*; (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              start_i,
  input  wire [DVD_W-1:0]  dividend_i,
  input  wire [DEN_W-1:0]  divisor_i,
  output logic             done_o,
  output logic [DVD_W-1:0] quotient_o,
  output logic [DEN_W-1:0] remainder_o
);

  localparam logic [CNT_W-1:0] LastStep = CNT_W'(DVD_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [DVD_W-1:0] dvd_q, dvd_d;
  logic [DEN_W-1:0] rem_q, rem_d;
  logic [DEN_W-1:0] dvs_q, dvs_d;
  logic [DEN_W:0]   trial;
  logic [DEN_W:0]   diff;
  logic             ge;

  // one restoring step: shift in the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_q, dvd_q[DVD_W-1]};
    diff  = trial - {1'b0, dvs_q};
    ge    = trial >= {1'b0, dvs_q};
  end

  // next state of the iteration
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    rem_d  = rem_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      rem_d  = '0;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
      dvd_d = {dvd_q[DVD_W-2:0], ge};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == LastStep) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // operand and result registers
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

  assign done_o      = done_q;
  assign quotient_o  = dvd_q;
  assign remainder_o = rem_q;

  `LPR_ASSERT(a_div_start_idle, start_i |-> !busy_q, "divider started while busy")
  `LPR_ASSERT_ALWAYS(a_div_done_pulse, done_q |=> !done_q, "divider done held longer than one cycle")

endmodule

`default_nettype wire

>>> src/lpr_dp.sv
`default_nettype none
`include "line_pixel_rasterizer_top_defines.svh"

module lpr_dp import lpr_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire in_t  in_data_i,
  input  wire cmd_t cmd_i,
  input  wire       out_ready_i,
  output sts_t      sts_o,
  output logic      out_valid_o,
  output out_t      out_data_o
);

  // line registers
  logic [COORD_W-1:0] sx_q, sy_q, ex_q, ey_q;
  mode_e              mode_q;
  logic [POS_W-1:0]   i_q, hi_q;
  logic [MARK_W-1:0]  mark_q;

  // slope registers
  logic [2*COORD_W-1:0]    p1_q;
  logic signed [NUM_W-1:0] p2_q;
  logic signed [NUM_W-1:0] num0_q;
  logic signed [Q_W-1:0]   q_q, a_q;
  logic [DEN_W-1:0]        r_q, b_q;

  // output register
  logic out_valid_q;
  out_t out_data_q, out_data_d;

  // load side
  logic               swap, vert, ysw;
  logic [COORD_W-1:0] ax, ay, bx, by, sy_d, ey_d;
  logic [POS_W-1:0]   lo_d, hi_d;
  mode_e              mode_d;

  // slope side
  logic [DX_W-1:0]         dx;
  logic signed [DY_W-1:0]  dy, d;
  logic [DY_W-1:0]         dy_mag;
  logic [DEN_W-1:0]        den;
  logic [NUM_W-1:0]        num_mag;
  logic [DVD_W-1:0]        dvd;
  logic [DEN_W-1:0]        dvs;
  logic                    div_done;
  logic [DVD_W-1:0]        quo;
  logic [DEN_W-1:0]        rem;
  logic                    neg, rnz;
  logic [Q_W-1:0]          qmag, qs;
  logic [DEN_W-1:0]        rs;
  logic [DEN_W:0]          r_sum;
  logic                    wrap;

  // emit side
  logic             q_neg, q_big, q_m1, rz;
  logic [POS_W-1:0] slope_row;
  logic             slope_off;

  // endpoint ordering and mode choice
  always_comb begin
    swap   = in_data_i.start_x > in_data_i.end_x;
    ax     = swap ? in_data_i.end_x   : in_data_i.start_x;
    ay     = swap ? in_data_i.end_y   : in_data_i.start_y;
    bx     = swap ? in_data_i.start_x : in_data_i.end_x;
    by     = swap ? in_data_i.start_y : in_data_i.end_y;
    vert   = ax == bx;
    ysw    = vert && (ay > by);
    sy_d   = ysw ? by : ay;
    ey_d   = ysw ? ay : by;
    if (vert) begin
      mode_d = MODE_VERT;
    end else if (ay == by) begin
      mode_d = MODE_HORIZ;
    end else begin
      mode_d = MODE_SLOPE;
    end
    lo_d = vert ? sy_d[COORD_W-1:FRAC_W] : ax[COORD_W-1:FRAC_W];
    hi_d = vert ? ey_d[COORD_W-1:FRAC_W] : bx[COORD_W-1:FRAC_W];
  end

  // line differences; i_q still holds the first column during the multiply
  always_comb begin
    dx      = ex_q - sx_q;
    dy      = $signed({1'b0, ey_q}) - $signed({1'b0, sy_q});
    d       = $signed({1'b0, i_q, {FRAC_W{1'b0}}}) - $signed({1'b0, ex_q});
    den     = {dx, {FRAC_W{1'b0}}};
    dy_mag  = dy[DY_W-1] ? DY_W'(-dy) : dy;
    num_mag = num0_q[NUM_W-1] ? NUM_W'(-num0_q) : num0_q;
  end

  // divider operands: start numerator over den, or step dy over dx
  always_comb begin
    if (cmd_i.div_sel_step) begin
      dvd = {{(DVD_W-DX_W){1'b0}}, dy_mag[DX_W-1:0]};
      dvs = {{(DEN_W-DX_W){1'b0}}, dx};
    end else begin
      dvd = num_mag[DVD_W-1:0];
      dvs = den;
    end
  end

  lpr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (dvd),
    .divisor_i   (dvs),
    .done_o      (div_done),
    .quotient_o  (quo),
    .remainder_o (rem)
  );

  // turn magnitude division into floor quotient and nonnegative remainder
  always_comb begin
    neg  = cmd_i.cap_step ? dy[DY_W-1] : num0_q[NUM_W-1];
    rnz  = rem != '0;
    qmag = {1'b0, quo[Q_W-2:0]};
    qs   = neg ? (~qmag + {{(Q_W-1){1'b0}}, ~rnz}) : qmag;
    rs   = (neg && rnz) ? (dvs - rem) : rem;
  end

  // incremental step of the row fraction
  always_comb begin
    r_sum = {1'b0, r_q} + {1'b0, b_q};
    wrap  = r_sum >= {1'b0, den};
  end

  // row of a sloped line: truncate toward zero, clamp into the grid
  always_comb begin
    q_neg = q_q[Q_W-1];
    q_m1  = &q_q;
    rz    = r_q == '0;
    q_big = !q_neg && (q_q[Q_W-2:POS_W] != '0);
    if (q_neg) begin
      slope_row = '0;
      slope_off = !(q_m1 && !rz);
    end else if (q_big) begin
      slope_row = POS_W'(GRID - 1);
      slope_off = 1'b1;
    end else begin
      slope_row = q_q[POS_W-1:0];
      slope_off = 1'b0;
    end
  end

  // pixel to present
  always_comb begin
    out_data_d.mark     = mark_q;
    out_data_d.last     = i_q == hi_q;
    out_data_d.off_grid = 1'b0;
    unique case (mode_q)
      MODE_VERT: begin
        out_data_d.pixel_column = sx_q[COORD_W-1:FRAC_W];
        out_data_d.pixel_row    = i_q;
      end
      MODE_HORIZ: begin
        out_data_d.pixel_column = i_q;
        out_data_d.pixel_row    = sy_q[COORD_W-1:FRAC_W];
      end
      default: begin
        out_data_d.pixel_column = i_q;
        out_data_d.pixel_row    = slope_row;
        out_data_d.off_grid     = slope_off;
      end
    endcase
  end

  // line and slope registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sx_q   <= ax;
      ex_q   <= bx;
      sy_q   <= sy_d;
      ey_q   <= ey_d;
      mode_q <= mode_d;
      i_q    <= lo_d;
      hi_q   <= hi_d;
      mark_q <= in_data_i.pen_mark;
    end else if (cmd_i.emit) begin
      i_q <= i_q + 1'b1;
    end
    if (cmd_i.mul) begin
      p1_q <= ey_q * dx;
      p2_q <= d * dy;
    end
    if (cmd_i.sum) begin
      num0_q <= $signed({2'b00, p1_q}) + p2_q;
    end
    if (cmd_i.cap_num) begin
      q_q <= qs;
      r_q <= rs;
    end else if (cmd_i.emit) begin
      q_q <= q_q + a_q + {{(Q_W-1){1'b0}}, wrap};
      r_q <= wrap ? DEN_W'(r_sum - {1'b0, den}) : r_sum[DEN_W-1:0];
    end
    if (cmd_i.cap_step) begin
      a_q <= qs;
      b_q <= {rs[DX_W-1:0], {FRAC_W{1'b0}}};
    end
  end

  // output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

  always_comb begin
    sts_o.slope    = mode_q == MODE_SLOPE;
    sts_o.last     = i_q == hi_q;
    sts_o.div_done = div_done;
    sts_o.out_free = !out_valid_q || out_ready_i;
  end

  `LPR_ASSERT(a_dp_rem_below_den, (cmd_i.emit && mode_q == MODE_SLOPE) |-> (r_q < den), "row remainder not below denominator")
  `LPR_ASSERT(a_dp_col_in_span, cmd_i.emit |-> (i_q <= hi_q), "pixel step ran past the line end")

endmodule

`default_nettype wire

>>> src/lpr_ctrl.sv
`default_nettype none
`include "line_pixel_rasterizer_top_defines.svh"

module lpr_ctrl import lpr_pkg::*; (
  input  wire       clk_i,
  input  wire       rst_ni,
  input  wire       in_valid_i,
  output logic      in_ready_o,
  input  wire sts_t sts_i,
  output cmd_t      cmd_o
);

  state_e state_q, state_d;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (in_valid_i) state_d = ST_MUL;
      ST_MUL:   state_d = sts_i.slope ? ST_SUM : ST_EMIT;
      ST_SUM:   state_d = ST_QGO;
      ST_QGO:   state_d = ST_QWAIT;
      ST_QWAIT: if (sts_i.div_done) state_d = ST_SGO;
      ST_SGO:   state_d = ST_SWAIT;
      ST_SWAIT: if (sts_i.div_done) state_d = ST_EMIT;
      ST_EMIT:  if (sts_i.out_free && sts_i.last) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:   cmd_o.mul = 1'b1;
      ST_SUM:   cmd_o.sum = 1'b1;
      ST_QGO:   cmd_o.div_start = 1'b1;
      ST_QWAIT: cmd_o.cap_num = sts_i.div_done;
      ST_SGO: begin
        cmd_o.div_start    = 1'b1;
        cmd_o.div_sel_step = 1'b1;
      end
      ST_SWAIT: begin
        cmd_o.div_sel_step = 1'b1;
        cmd_o.cap_step     = sts_i.div_done;
      end
      ST_EMIT:  cmd_o.emit = sts_i.out_free;
      default:  cmd_o = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `LPR_ASSERT(a_ctrl_emit_free, cmd_o.emit |-> sts_i.out_free, "pixel issued into a full output stage")
  `LPR_ASSERT(a_ctrl_done_waiting, sts_i.div_done |-> (state_q == ST_QWAIT || state_q == ST_SWAIT), "divider finished outside a wait state")

endmodule

`default_nettype wire

>>> src/line_pixel_rasterizer_top.sv
// Line pixel rasterizer.
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one segment: two
// endpoints in unsigned fixed point with 8 fraction bits and a mark byte.
// Output channel (out_valid_o / out_ready_i / out_data_o) gives one transfer
// per grid pixel, columns rising (rows rising for vertical segments), last set on the final pixel of the segment.
// Vertical and horizontal segments go from the load through the multiply
// state straight to pixel output. Sloped segments: the start row and the
// slope are each found by a 27-step shift-subtract divider, one bit per
// cycle, before the first pixel is issued. After that one pixel per cycle
// while the receiver takes them; a segment covers at most 32 pixels.
// A new segment is taken once the final pixel sits in the output register.
// Rows outside the grid are clamped and flagged with off_grid.
// A stalled receiver holds the output register and the pixel sequence waits.
// Reset is asynchronous, active low: the controller returns to idle, the
// divider goes idle and the output register empties; nothing else needs clearing.
`default_nettype none

module line_pixel_rasterizer_top import lpr_pkg::*; (
  input  wire      clk_i,
  input  wire      rst_ni,
  input  wire      in_valid_i,
  output logic     in_ready_o,
  input  wire in_t in_data_i,
  output logic     out_valid_o,
  input  wire      out_ready_i,
  output out_t     out_data_o
);

  cmd_t cmd;
  sts_t sts;

  // sequencing
  lpr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  // arithmetic and output stage
  lpr_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .out_ready_i (out_ready_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

`default_nettype wire

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import lpr_pkg::*;

  // the block never emits more pixels than this for one segment
  localparam int MAX_PIXELS = 32;
  localparam int MAX_IDLE   = 19;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  in_t  in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  out_t out_data;

  // expected pixels, oldest first
  out_t pending_pixels[$];
  int   mismatch_count = 0;
  // receiver hold-off, counted down by the pixel sink
  int   hold_cycles = 0;
  // when set, neither side idles
  bit   no_idle = 1'b0;

  line_pixel_rasterizer_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_data_o  (out_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // run limit
  initial begin
    #30ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  task automatic flag_mismatch(input string what);
    mismatch_count++;
    if (mismatch_count <= 50) begin
      $display("mismatch at %0t: %s", $realtime, what);
    end
  endtask

  function automatic int draw_gap();
    return no_idle ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  // pixels of one segment, appended to the expected queue
  function automatic void rasterize_segment(input in_t seg);
    longint sx, sy, ex, ey, t, lo, hi, i, dx, dy, num, den, col, row;
    mode_e  mode;
    int     n;
    out_t   px;
    sx = seg.start_x;
    sy = seg.start_y;
    ex = seg.end_x;
    ey = seg.end_y;
    // x must not fall from start to end
    if (sx > ex) begin
      t = sx; sx = ex; ex = t;
      t = sy; sy = ey; ey = t;
    end
    if (sx == ex) begin
      if (sy > ey) begin
        t = sy; sy = ey; ey = t;
      end
      mode = MODE_VERT;
      lo = sy >> FRAC_W;
      hi = ey >> FRAC_W;
    end else begin
      mode = (sy == ey) ? MODE_HORIZ : MODE_SLOPE;
      lo = sx >> FRAC_W;
      hi = ex >> FRAC_W;
    end
    dx = ex - sx;
    dy = ey - sy;
    den = dx << FRAC_W;
    n = 0;
    for (i = lo; i <= hi && n < MAX_PIXELS; i++) begin
      case (mode)
        MODE_VERT: begin
          col = sx >> FRAC_W;
          row = i;
        end
        MODE_HORIZ: begin
          col = i;
          row = sy >> FRAC_W;
        end
        default: begin
          // exact rational row, signed division truncates toward zero
          col = i;
          num = ey * dx + dy * ((i << FRAC_W) - ex);
          row = num / den;
        end
      endcase
      px.off_grid = 1'b0;
      if (col < 0) begin
        col = 0;
        px.off_grid = 1'b1;
      end
      if (col > GRID - 1) begin
        col = GRID - 1;
        px.off_grid = 1'b1;
      end
      if (row < 0) begin
        row = 0;
        px.off_grid = 1'b1;
      end
      if (row > GRID - 1) begin
        row = GRID - 1;
        px.off_grid = 1'b1;
      end
      px.pixel_column = col[POS_W-1:0];
      px.pixel_row    = row[POS_W-1:0];
      px.mark         = seg.pen_mark;
      px.last         = (i == hi) || (n == MAX_PIXELS - 1);
      pending_pixels.insert(pending_pixels.size(), px);
      n++;
    end
  endfunction

  // compare one received pixel with the oldest expectation
  task automatic check_pixel(input out_t got);
    out_t want;
    if (pending_pixels.size() == 0) begin
      flag_mismatch($sformatf("unexpected pixel col %0d row %0d",
                              got.pixel_column, got.pixel_row));
    end else begin
      want = pending_pixels.pop_front();
      if (got.pixel_column !== want.pixel_column)
        flag_mismatch($sformatf("pixel_column %0d, want %0d",
                                got.pixel_column, want.pixel_column));
      if (got.pixel_row !== want.pixel_row)
        flag_mismatch($sformatf("pixel_row %0d, want %0d (col %0d)",
                                got.pixel_row, want.pixel_row, want.pixel_column));
      if (got.mark !== want.mark)
        flag_mismatch($sformatf("mark %0h, want %0h", got.mark, want.mark));
      if (got.off_grid !== want.off_grid)
        flag_mismatch($sformatf("off_grid %b, want %b (col %0d row %0d)",
                                got.off_grid, want.off_grid,
                                want.pixel_column, want.pixel_row));
      if (got.last !== want.last)
        flag_mismatch($sformatf("last %b, want %b (col %0d row %0d)",
                                got.last, want.last,
                                want.pixel_column, want.pixel_row));
    end
  endtask

  // pixel sink: checks each transfer and paces out_ready
  initial begin : pixel_sink
    int stall_left;
    stall_left = 0;
    wait (rst_n);
    forever begin
      @(posedge clk);
      if (out_valid && out_ready) check_pixel(out_data);
      if (hold_cycles > 0) begin
        out_ready <= 1'b0;
        hold_cycles--;
      end else if (out_ready) begin
        if (out_valid) begin
          stall_left = draw_gap();
          if (stall_left != 0) out_ready <= 1'b0;
        end
      end else if (stall_left <= 1) begin
        out_ready  <= 1'b1;
        stall_left = 0;
      end else begin
        stall_left--;
      end
    end
  end

  // one segment transfer; valid stays high for a back-to-back follower
  task automatic send_segment(input in_t seg);
    int gap;
    gap = draw_gap();
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= seg;
    do @(posedge clk); while (!in_ready);
    rasterize_segment(seg);
  endtask

  task automatic send_coords(input int sx, input int sy, input int ex, input int ey,
                             input int pen);
    in_t seg;
    seg.start_x  = sx[COORD_W-1:0];
    seg.start_y  = sy[COORD_W-1:0];
    seg.end_x    = ex[COORD_W-1:0];
    seg.end_y    = ey[COORD_W-1:0];
    seg.pen_mark = pen[MARK_W-1:0];
    send_segment(seg);
  endtask

  // random segment, biased toward axis-aligned, single point and short steep lines
  function automatic in_t random_segment();
    in_t seg;
    int  kind, delta, sx;
    seg.start_x  = COORD_W'($urandom_range(0, 8191));
    seg.start_y  = COORD_W'($urandom_range(0, 8191));
    seg.end_x    = COORD_W'($urandom_range(0, 8191));
    seg.end_y    = COORD_W'($urandom_range(0, 8191));
    seg.pen_mark = MARK_W'($urandom_range(0, 255));
    kind = $urandom_range(0, 9);
    case (kind)
      0, 1: seg.end_x = seg.start_x;
      2: seg.end_y = seg.start_y;
      3: begin
        seg.end_x = seg.start_x;
        seg.end_y = seg.start_y;
      end
      4, 5: begin
        // short run in x, steep slope, rows often land off the grid
        sx = seg.start_x;
        delta = $urandom_range(1, 600);
        if ($urandom_range(0, 1) != 0)
          seg.end_x = COORD_W'((sx + delta > 8191) ? 8191 : sx + delta);
        else
          seg.end_x = COORD_W'((sx >= delta) ? sx - delta : 0);
      end
      default: ;
    endcase
    return seg;
  endfunction

  // single points at the coordinate extremes
  task automatic test_single_points();
    send_coords(0, 0, 0, 0, 8'h00);
    send_coords(8191, 8191, 8191, 8191, 8'hff);
  endtask

  // vertical lines, both y orders and a one-row span
  task automatic test_vertical();
    send_coords(0, 0, 0, 8191, 8'h5a);
    send_coords(8191, 8191, 8191, 0, 8'ha5);
    send_coords(100, 300, 100, 400, 8'h2a);
  endtask

  // horizontal lines, both x orders
  task automatic test_horizontal();
    send_coords(0, 8191, 8191, 8191, 8'h23);
    send_coords(8191, 0, 0, 0, 8'hdc);
  endtask

  // sloped lines: diagonals, off-grid rows, small negative rows, swapped ends
  task automatic test_sloped();
    send_coords(0, 0, 8191, 8191, 8'h01);
    send_coords(0, 8191, 8191, 0, 8'h80);
    send_coords(255, 0, 256, 8191, 8'h7f);
    send_coords(255, 8191, 256, 0, 8'hfe);
    send_coords(255, 0, 256, 1, 8'h55);
    send_coords(256, 8191, 255, 0, 8'haa);
    send_coords(10, 20, 200, 3000, 8'h40);
  endtask

  // random lines with occasional stretches of no idling
  task automatic test_random_lines(input int count);
    int k;
    for (k = 0; k < count; k++) begin
      no_idle = (k % 80) >= 68;
      send_segment(random_segment());
    end
    no_idle = 1'b0;
  endtask

  // receiver holds off while segments keep coming, so the input stalls
  task automatic test_backpressure(input int count);
    int k;
    hold_cycles = 400;
    no_idle = 1'b1;
    for (k = 0; k < count; k++) send_segment(random_segment());
    no_idle = 1'b0;
  endtask

  initial begin : run
    int k;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_single_points();
    test_vertical();
    test_horizontal();
    test_sloped();
    test_random_lines(400);
    test_backpressure(30);
    test_random_lines(40);
    in_valid <= 1'b0;
    // drain, then allow for a sloped segment's full latency
    for (k = 0; k < 4000 && pending_pixels.size() != 0; k++) @(posedge clk);
    repeat (80) @(posedge clk);
    if (pending_pixels.size() != 0)
      flag_mismatch($sformatf("%0d pixels never arrived", pending_pixels.size()));
    if (mismatch_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
